// ===== hw/rtl/des_pkg.sv =====
package des_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_DPHI_CUT     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_RANGE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LEAD_PT_LOW  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LEAD_PT_HIGH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SUB_PT_LOW   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SUB_PT_HIGH  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ETA_LIMIT    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_ASYM_MAX     = 3'd7;

	// Register values after reset
	localparam logic [11:0] DPHI_CUT_RST     = 12'd1707;
	localparam logic [9:0]  VERTEX_RANGE_RST = 10'd240;
	localparam logic [15:0] LEAD_PT_LOW_RST  = 16'd480;
	localparam logic [15:0] LEAD_PT_HIGH_RST = 16'd1200;
	localparam logic [15:0] SUB_PT_LOW_RST   = 16'd200;
	localparam logic [15:0] SUB_PT_HIGH_RST  = 16'd1200;
	localparam logic [10:0] ETA_LIMIT_RST    = 11'd410;
	localparam logic [8:0]  ASYM_MAX_RST     = 9'd256;

	// Fixed thresholds: |eta| of two units, hard jet at 120 GeV, mid jet at 50 GeV
	localparam logic [11:0] ETA_TWO = 12'd512;
	localparam logic [15:0] HARD_PT = 16'd480;
	localparam logic [15:0] MID_PT  = 16'd200;
	localparam logic [1:0]  MID_COUNT_MAX = 2'd2;

	// Half turn of azimuth and a full turn
	localparam logic [12:0] PHI_HALF_TURN = 13'd2048;
	localparam logic [12:0] PHI_FULL_TURN = 13'd4096;

	// Reason codes
	localparam logic [3:0] RSN_PASS      = 4'd0;
	localparam logic [3:0] RSN_FLAGS     = 4'd1;
	localparam logic [3:0] RSN_VERTEX    = 4'd2;
	localparam logic [3:0] RSN_UNSORTED  = 4'd3;
	localparam logic [3:0] RSN_NO_PAIR   = 4'd4;
	localparam logic [3:0] RSN_DPHI      = 4'd5;
	localparam logic [3:0] RSN_LEAD_PT   = 4'd6;
	localparam logic [3:0] RSN_SUB_PT    = 4'd7;
	localparam logic [3:0] RSN_ETA       = 4'd8;
	localparam logic [3:0] RSN_ASYM      = 4'd9;
	localparam logic [3:0] RSN_JET_COUNT = 4'd10;

	// One jet as kept in the event state
	typedef struct packed {
		logic [15:0]        pt;
		logic signed [11:0] eta;
		logic signed [11:0] phi;
	} jet_t;

	// Absolute value of a pseudorapidity; the most negative code maps to 2048.
	function automatic logic [11:0] abs_eta(input logic signed [11:0] x);
		return x[11] ? 12'(-x) : 12'(x);
	endfunction

	// Absolute value of a vertex position.
	function automatic logic [10:0] abs_vz(input logic signed [10:0] x);
		return x[10] ? 11'(-x) : 11'(x);
	endfunction

endpackage

// ===== hw/rtl/dijet_event_selector.sv =====
// Channel  | Direction | Transfer carries
// s_axis   | in        | one jet (or an empty marker), tlast on the final item of an event
// m_axis   | out       | one verdict per event: pass flag and reason code
// cfg      | in        | single-cycle register write, no read-back
//
// One item is taken in every cycle unless a stall backs up to s_tready. A verdict
// follows the event's last item through the input, snapshot and result registers.
// Items that do not end an event never wait on the output side; a stall at
// m_axis holds only event ends and then backs up to s_tready.
// arst_n clears the event state, the valid bits and the registers to their
// default values.
module dijet_event_selector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// jet_pt[15:0], jet_eta[27:16], jet_phi[39:28], collision_ok[40], noise_ok[41],
	// vertex_z[52:42], zero[55:53]
	input  logic [55:0]                           s_tdata,
	// jet_valid[0]
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	// Result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// event_pass[0], fail_reason[4:1], zero[7:5]
	output logic [7:0]                            m_tdata,
	// Configuration
	input  logic                                  cfg_we,
	input  logic [des_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [des_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// Configuration registers
	logic [11:0] dphi_cut_q;
	logic [9:0]  vertex_range_q;
	logic [15:0] lead_pt_low_q;
	logic [15:0] lead_pt_high_q;
	logic [15:0] sub_pt_low_q;
	logic [15:0] sub_pt_high_q;
	logic [10:0] eta_limit_q;
	logic [8:0]  asym_max_q;

	// Input stage
	logic                     v_s1;
	logic                     jet_valid_s1;
	logic                     last_s1;
	logic                     flags_ok_s1;
	logic signed [10:0]       vz_s1;
	des_pkg::jet_t            jet_s1;

	// Running event state
	logic                     lead_found_q;
	logic                     sub_found_q;
	logic                     order_broken_q;
	logic                     hard_seen_q;
	logic [1:0]               mid_count_q;
	logic [15:0]              prev_pt_q;
	des_pkg::jet_t            lead_q;
	des_pkg::jet_t            sub_q;

	// Next event state
	logic                     lead_found_d;
	logic                     sub_found_d;
	logic                     order_broken_d;
	logic                     hard_seen_d;
	logic [1:0]               mid_count_d;
	logic [15:0]              prev_pt_d;
	des_pkg::jet_t            lead_d;
	des_pkg::jet_t            sub_d;
	logic [11:0]              abs_eta_s1;

	// Event snapshot stage
	logic                     v_s2;
	logic                     flags_ok_s2;
	logic signed [10:0]       vz_s2;
	logic                     lead_found_s2;
	logic                     sub_found_s2;
	logic                     order_broken_s2;
	logic                     hard_seen_s2;
	logic [1:0]               mid_count_s2;
	des_pkg::jet_t            lead_s2;
	des_pkg::jet_t            sub_s2;

	// Result register
	logic                     out_valid_q;
	logic                     out_pass_q;
	logic [3:0]               out_reason_q;

	// Flow control
	logic                     ready_out;
	logic                     ready_s2;
	logic                     fire_s1;
	logic                     fire_s2;

	// Verdict logic
	logic [3:0]               reason;
	logic signed [12:0]       dphi_raw;
	logic [12:0]              dphi_abs;
	logic [12:0]              dphi_wrap;
	logic [16:0]              pt_sum;
	logic [15:0]              pt_diff;
	logic [25:0]              asym_lhs;
	logic [25:0]              asym_rhs;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dphi_cut_q     <= des_pkg::DPHI_CUT_RST;
			vertex_range_q <= des_pkg::VERTEX_RANGE_RST;
			lead_pt_low_q  <= des_pkg::LEAD_PT_LOW_RST;
			lead_pt_high_q <= des_pkg::LEAD_PT_HIGH_RST;
			sub_pt_low_q   <= des_pkg::SUB_PT_LOW_RST;
			sub_pt_high_q  <= des_pkg::SUB_PT_HIGH_RST;
			eta_limit_q    <= des_pkg::ETA_LIMIT_RST;
			asym_max_q     <= des_pkg::ASYM_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				des_pkg::REG_DPHI_CUT:     dphi_cut_q     <= cfg_data[11:0];
				des_pkg::REG_VERTEX_RANGE: vertex_range_q <= cfg_data[9:0];
				des_pkg::REG_LEAD_PT_LOW:  lead_pt_low_q  <= cfg_data[15:0];
				des_pkg::REG_LEAD_PT_HIGH: lead_pt_high_q <= cfg_data[15:0];
				des_pkg::REG_SUB_PT_LOW:   sub_pt_low_q   <= cfg_data[15:0];
				des_pkg::REG_SUB_PT_HIGH:  sub_pt_high_q  <= cfg_data[15:0];
				des_pkg::REG_ETA_LIMIT:    eta_limit_q    <= cfg_data[10:0];
				des_pkg::REG_ASYM_MAX:     asym_max_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Each stage takes new data when it is empty or its content moves on.
	// An item that does not end an event leaves the input stage at once.
	assign ready_out = !out_valid_q || m_tready;
	assign ready_s2  = !v_s2 || ready_out;
	assign fire_s2   = v_s2 && ready_out;
	assign fire_s1   = v_s1 && (!last_s1 || ready_s2);
	assign s_tready  = !v_s1 || fire_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			jet_valid_s1 <= s_tuser;
			last_s1      <= s_tlast;
			jet_s1.pt    <= s_tdata[15:0];
			jet_s1.eta   <= s_tdata[27:16];
			jet_s1.phi   <= s_tdata[39:28];
			flags_ok_s1  <= s_tdata[40] & s_tdata[41];
			vz_s1        <= s_tdata[52:42];
		end
	end

	// Event state update for the jet in the input stage
	assign abs_eta_s1 = des_pkg::abs_eta(jet_s1.eta);

	always_comb begin
		lead_found_d   = lead_found_q;
		sub_found_d    = sub_found_q;
		order_broken_d = order_broken_q;
		hard_seen_d    = hard_seen_q;
		mid_count_d    = mid_count_q;
		prev_pt_d      = prev_pt_q;
		lead_d         = lead_q;
		sub_d          = sub_q;
		if (jet_valid_s1) begin
			if (abs_eta_s1 <= des_pkg::ETA_TWO) begin
				if (jet_s1.pt > des_pkg::HARD_PT) begin
					hard_seen_d = 1'b1;
				end
				if (jet_s1.pt > des_pkg::MID_PT && mid_count_q < des_pkg::MID_COUNT_MAX) begin
					mid_count_d = mid_count_q + 2'd1;
				end
			end
			// Sort order is watched up to and including the subleading jet.
			if (!sub_found_q) begin
				if (jet_s1.pt > prev_pt_q) begin
					order_broken_d = 1'b1;
				end
				prev_pt_d = jet_s1.pt;
				if (abs_eta_s1 < des_pkg::ETA_TWO) begin
					if (!lead_found_q) begin
						lead_d       = jet_s1;
						lead_found_d = 1'b1;
					end else begin
						sub_d       = jet_s1;
						sub_found_d = 1'b1;
					end
				end
			end
		end
	end

	// Running state: cleared after each event end, else updated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_found_q   <= 1'b0;
			sub_found_q    <= 1'b0;
			order_broken_q <= 1'b0;
			hard_seen_q    <= 1'b0;
			mid_count_q    <= 2'd0;
			prev_pt_q      <= '1;
		end else if (fire_s1) begin
			if (last_s1) begin
				lead_found_q   <= 1'b0;
				sub_found_q    <= 1'b0;
				order_broken_q <= 1'b0;
				hard_seen_q    <= 1'b0;
				mid_count_q    <= 2'd0;
				prev_pt_q      <= '1;
			end else begin
				lead_found_q   <= lead_found_d;
				sub_found_q    <= sub_found_d;
				order_broken_q <= order_broken_d;
				hard_seen_q    <= hard_seen_d;
				mid_count_q    <= mid_count_d;
				prev_pt_q      <= prev_pt_d;
			end
		end
	end

	// The stored jets are read only when their found bit is set.
	always_ff @(posedge clk) begin
		if (fire_s1 && !last_s1) begin
			lead_q <= lead_d;
			sub_q  <= sub_d;
		end
	end

	// Snapshot of the finished event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= fire_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && fire_s1 && last_s1) begin
			flags_ok_s2     <= flags_ok_s1;
			vz_s2           <= vz_s1;
			lead_found_s2   <= lead_found_d;
			sub_found_s2    <= sub_found_d;
			order_broken_s2 <= order_broken_d;
			hard_seen_s2    <= hard_seen_d;
			mid_count_s2    <= mid_count_d;
			lead_s2         <= lead_d;
			sub_s2          <= sub_d;
		end
	end

	// Angle between the two jets, wrapped into a half turn
	assign dphi_raw  = 13'(lead_s2.phi) - 13'(sub_s2.phi);
	assign dphi_abs  = dphi_raw[12] ? 13'(-dphi_raw) : 13'(dphi_raw);
	assign dphi_wrap = (dphi_abs > des_pkg::PHI_HALF_TURN) ?
		des_pkg::PHI_FULL_TURN - dphi_abs : dphi_abs;

	// Asymmetry: (l - s) * 256 against asym_max * (l + s); a rising pair passes.
	assign pt_sum   = {1'b0, lead_s2.pt} + {1'b0, sub_s2.pt};
	assign pt_diff  = lead_s2.pt - sub_s2.pt;
	assign asym_lhs = {2'b00, pt_diff, 8'h00};
	assign asym_rhs = 26'(asym_max_q) * 26'(pt_sum);

	// Cuts in fixed order; the first one that fails names the reason.
	always_comb begin
		if (!flags_ok_s2) begin
			reason = des_pkg::RSN_FLAGS;
		end else if (des_pkg::abs_vz(vz_s2) > {1'b0, vertex_range_q}) begin
			reason = des_pkg::RSN_VERTEX;
		end else if (order_broken_s2) begin
			reason = des_pkg::RSN_UNSORTED;
		end else if (!lead_found_s2 || !sub_found_s2) begin
			reason = des_pkg::RSN_NO_PAIR;
		end else if (dphi_wrap < {1'b0, dphi_cut_q}) begin
			reason = des_pkg::RSN_DPHI;
		end else if (lead_s2.pt > lead_pt_high_q || lead_s2.pt < lead_pt_low_q) begin
			reason = des_pkg::RSN_LEAD_PT;
		end else if (sub_s2.pt > sub_pt_high_q || sub_s2.pt < sub_pt_low_q) begin
			reason = des_pkg::RSN_SUB_PT;
		end else if (des_pkg::abs_eta(lead_s2.eta) > {1'b0, eta_limit_q} ||
				des_pkg::abs_eta(sub_s2.eta) > {1'b0, eta_limit_q}) begin
			reason = des_pkg::RSN_ETA;
		end else if (lead_s2.pt >= sub_s2.pt && asym_lhs > asym_rhs) begin
			reason = des_pkg::RSN_ASYM;
		end else if (!(hard_seen_s2 && mid_count_s2 >= des_pkg::MID_COUNT_MAX)) begin
			reason = des_pkg::RSN_JET_COUNT;
		end else begin
			reason = des_pkg::RSN_PASS;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			out_pass_q   <= (reason == des_pkg::RSN_PASS);
			out_reason_q <= reason;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_reason_q, out_pass_q};

	// A verdict passes exactly when its reason says so.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pass_q == (out_reason_q == des_pkg::RSN_PASS)))
		else $error("pass flag disagrees with reason code");

	// Reason codes stay within the defined set.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_reason_q <= des_pkg::RSN_JET_COUNT))
		else $error("undefined reason code");

	// An event end leaves the running state cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (!lead_found_q && !sub_found_q && !order_broken_q &&
			!hard_seen_q && mid_count_q == 2'd0 && prev_pt_q == 16'hFFFF))
		else $error("event state not cleared after event end");

	// The subleading jet is never found before the leading jet.
	assert property (@(posedge clk) disable iff (!arst_n)
		sub_found_q |-> lead_found_q)
		else $error("subleading jet held without a leading jet");

	// An event end held in the snapshot stage is not overwritten while stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ready_out) |=> (v_s2 && $stable(lead_s2) && $stable(sub_s2)))
		else $error("event snapshot lost during stall");

endmodule
